FILE: rtl/core/fms_pkg.sv
`timescale 1ns / 1ps
// Package for the flight mode supervisor: mode, event and action codes,
// the decision record passed from the decoder to the result serializer.
// No dependencies.
package fms_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int EVT_W          = 4;
    localparam int ACT_W          = 4;
    localparam int MODE_W         = 2;
    localparam int DEBOUNCE_W     = 32;
    localparam int NOW_W          = 32;
    localparam int MAX_ACTS       = 3;
    localparam int CNT_W          = 2;

    localparam logic [DEBOUNCE_W-1:0] ARM_DEBOUNCE_RST = DEBOUNCE_W'(1000);

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [EVT_W-1:0]  t_event;
    typedef logic [CNT_W-1:0]  t_count;

    localparam t_mode MODE_CAL  = 2'd0;
    localparam t_mode MODE_DIAG = 2'd1;
    localparam t_mode MODE_RUN  = 2'd2;

    localparam t_event EV_CAL_OK       = 4'd0;
    localparam t_event EV_CAL_FAIL     = 4'd1;
    localparam t_event EV_CAL_TIMEOUT  = 4'd2;
    localparam t_event EV_LOWBATT_CUT  = 4'd3;
    localparam t_event EV_ARM          = 4'd4;
    localparam t_event EV_RECAL        = 4'd5;
    localparam t_event EV_DISARM       = 4'd6;
    localparam t_event EV_SWITCH       = 4'd7;
    localparam t_event EV_LINK_LOST    = 4'd8;
    localparam t_event EV_IMU_FAIL     = 4'd9;
    localparam t_event EV_LOWBATT_CRIT = 4'd10;
    localparam t_event EV_TILT         = 4'd11;

    localparam t_action ACT_NONE       = 4'd0;
    localparam t_action ACT_CAL_OK     = 4'd1;
    localparam t_action ACT_MODE       = 4'd2;
    localparam t_action ACT_CAL_FAIL   = 4'd3;
    localparam t_action ACT_MOTORS_OFF = 4'd4;
    localparam t_action ACT_LOWBATT    = 4'd5;
    localparam t_action ACT_ERROR      = 4'd6;
    localparam t_action ACT_RAMP_DOWN  = 4'd7;
    localparam t_action ACT_PID_RESET  = 4'd8;

    // Outcome of one event: the ordered action list, its length and the
    // state that the event leaves behind.
    typedef struct packed {
        t_action act0;
        t_action act1;
        t_action act2;
        t_count  count;
        t_mode   mode;
        logic    cal;
        logic    rec_time;
    } t_decision;

endpackage

FILE: rtl/core/fms_evt_if.sv
`timescale 1ns / 1ps
// Event channel of the flight mode supervisor: valid/ready and the event payload.
// Depends on fms_pkg.
interface fms_evt_if;
    logic                          valid;
    logic                          ready;
    logic [fms_pkg::EVT_W-1:0]     event_code;
    logic [fms_pkg::NOW_W-1:0]     now_ms;

    modport source (output valid, output event_code, output now_ms, input ready);
    modport sink   (input valid, input event_code, input now_ms, output ready);
endinterface

FILE: rtl/core/fms_res_if.sv
`timescale 1ns / 1ps
// Result channel of the flight mode supervisor: valid/ready and the action payload.
// Depends on fms_pkg.
interface fms_res_if;
    logic                          valid;
    logic                          ready;
    logic [fms_pkg::ACT_W-1:0]     action_code;
    logic [fms_pkg::MODE_W-1:0]    new_mode;
    logic                          calib_ok_flag;
    logic                          last_action;

    modport source (output valid, output action_code, output new_mode,
                    output calib_ok_flag, output last_action, input ready);
    modport sink   (input valid, input action_code, input new_mode,
                    input calib_ok_flag, input last_action, output ready);
endinterface

FILE: rtl/core/fms_decode.sv
`timescale 1ns / 1ps
// Combinational event decoder: mode transitions, arm debounce check, action list.
// Depends on fms_pkg.
module fms_decode #(
    parameter int TIME_WIDTH = fms_pkg::TIME_WIDTH_DEF
) (
    input  fms_pkg::t_event                  i_event,
    input  logic [TIME_WIDTH-1:0]            i_now,
    input  fms_pkg::t_mode                   i_mode,
    input  logic                             i_cal,
    input  logic [TIME_WIDTH-1:0]            i_dtime,
    input  logic [fms_pkg::DEBOUNCE_W-1:0]   i_debounce,
    output fms_pkg::t_decision               o_dec
);

    localparam int CW = (TIME_WIDTH > fms_pkg::DEBOUNCE_W) ? TIME_WIDTH : fms_pkg::DEBOUNCE_W;

    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_arm_ok;

    // Elapsed time wraps modulo 2^TIME_WIDTH.
    assign w_elapsed = i_now - i_dtime;
    assign w_arm_ok  = i_cal && (CW'(w_elapsed) >= CW'(i_debounce));

    always_comb begin
        o_dec          = '0;
        o_dec.act0     = fms_pkg::ACT_NONE;
        o_dec.act1     = fms_pkg::ACT_NONE;
        o_dec.act2     = fms_pkg::ACT_NONE;
        o_dec.count    = 2'd1;
        o_dec.mode     = i_mode;
        o_dec.cal      = i_cal;
        o_dec.rec_time = 1'b0;
        unique case (i_mode)
            fms_pkg::MODE_CAL: begin
                unique case (i_event) inside
                    fms_pkg::EV_CAL_OK: begin
                        o_dec.mode  = fms_pkg::MODE_DIAG;
                        o_dec.cal   = 1'b1;
                        o_dec.act0  = fms_pkg::ACT_CAL_OK;
                        o_dec.act1  = fms_pkg::ACT_MODE;
                        o_dec.count = 2'd2;
                    end
                    fms_pkg::EV_CAL_FAIL, fms_pkg::EV_CAL_TIMEOUT: begin
                        o_dec.act0 = fms_pkg::ACT_CAL_FAIL;
                    end
                    fms_pkg::EV_LOWBATT_CUT: begin
                        o_dec.mode  = fms_pkg::MODE_DIAG;
                        o_dec.act0  = fms_pkg::ACT_MOTORS_OFF;
                        o_dec.act1  = fms_pkg::ACT_LOWBATT;
                        o_dec.count = 2'd2;
                    end
                    default: begin
                        o_dec.act0 = fms_pkg::ACT_NONE;
                    end
                endcase
            end
            fms_pkg::MODE_DIAG: begin
                unique case (i_event) inside
                    fms_pkg::EV_ARM: begin
                        if (w_arm_ok) begin
                            o_dec.mode = fms_pkg::MODE_RUN;
                            o_dec.act0 = fms_pkg::ACT_MODE;
                        end else begin
                            o_dec.act0 = fms_pkg::ACT_ERROR;
                        end
                    end
                    fms_pkg::EV_RECAL: begin
                        o_dec.mode = fms_pkg::MODE_CAL;
                        o_dec.cal  = 1'b0;
                        o_dec.act0 = fms_pkg::ACT_MODE;
                    end
                    fms_pkg::EV_LOWBATT_CUT: begin
                        o_dec.act0  = fms_pkg::ACT_MOTORS_OFF;
                        o_dec.act1  = fms_pkg::ACT_LOWBATT;
                        o_dec.count = 2'd2;
                    end
                    default: begin
                        o_dec.act0 = fms_pkg::ACT_NONE;
                    end
                endcase
            end
            fms_pkg::MODE_RUN: begin
                unique case (i_event) inside
                    fms_pkg::EV_DISARM, fms_pkg::EV_SWITCH,
                    fms_pkg::EV_LINK_LOST, fms_pkg::EV_IMU_FAIL: begin
                        o_dec.mode     = fms_pkg::MODE_DIAG;
                        o_dec.rec_time = 1'b1;
                        o_dec.act0     = fms_pkg::ACT_RAMP_DOWN;
                        o_dec.act1     = fms_pkg::ACT_PID_RESET;
                        o_dec.act2     = fms_pkg::ACT_MODE;
                        o_dec.count    = 2'd3;
                    end
                    fms_pkg::EV_LOWBATT_CRIT: begin
                        o_dec.mode     = fms_pkg::MODE_DIAG;
                        o_dec.rec_time = 1'b1;
                        o_dec.act0     = fms_pkg::ACT_RAMP_DOWN;
                        o_dec.act1     = fms_pkg::ACT_PID_RESET;
                        o_dec.act2     = fms_pkg::ACT_LOWBATT;
                        o_dec.count    = 2'd3;
                    end
                    fms_pkg::EV_LOWBATT_CUT, fms_pkg::EV_TILT: begin
                        o_dec.mode     = fms_pkg::MODE_DIAG;
                        o_dec.rec_time = 1'b1;
                        o_dec.act0     = fms_pkg::ACT_MOTORS_OFF;
                        o_dec.act1     = fms_pkg::ACT_PID_RESET;
                        o_dec.act2     = fms_pkg::ACT_MODE;
                        o_dec.count    = 2'd3;
                    end
                    default: begin
                        o_dec.act0 = fms_pkg::ACT_NONE;
                    end
                endcase
            end
            default: begin
                // Corrupted mode code: fall back to diagnostic with motors off.
                o_dec.mode  = fms_pkg::MODE_DIAG;
                o_dec.act0  = fms_pkg::ACT_MOTORS_OFF;
                o_dec.act1  = fms_pkg::ACT_ERROR;
                o_dec.count = 2'd2;
            end
        endcase
    end

endmodule

FILE: rtl/core/fms_serializer.sv
`timescale 1ns / 1ps
// Result register that plays out the action list of one event, one transfer per action.
// Depends on fms_pkg and fms_res_if.
module fms_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  fms_pkg::t_decision i_dec,
    output logic               o_can_load,
    fms_res_if.source          o_res
);

    logic                      r_valid;
    fms_pkg::t_action          r_acts [fms_pkg::MAX_ACTS];
    fms_pkg::t_count           r_cnt;
    fms_pkg::t_count           r_idx;
    fms_pkg::t_mode            r_mode;
    logic                      r_cal;
    logic                      w_last;
    logic                      w_xfer;

    assign w_last     = (r_idx == (r_cnt - 2'd1));
    assign w_xfer     = r_valid && o_res.ready;
    assign o_can_load = !r_valid || (w_xfer && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_xfer) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acts[0] <= i_dec.act0;
            r_acts[1] <= i_dec.act1;
            r_acts[2] <= i_dec.act2;
            r_cnt     <= i_dec.count;
            r_mode    <= i_dec.mode;
            r_cal     <= i_dec.cal;
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    o_res.action_code = r_acts[0];
            2'd1:    o_res.action_code = r_acts[1];
            default: o_res.action_code = r_acts[2];
        endcase
    end

    assign o_res.valid         = r_valid;
    assign o_res.new_mode      = r_mode;
    assign o_res.calib_ok_flag = r_cal;
    assign o_res.last_action   = w_last;

endmodule

FILE: rtl/core/flight_mode_supervisor_unit.sv
`timescale 1ns / 1ps
// Top level of the flight mode supervisor: input register, mode state, debounce
// register, decoder and result serializer. Depends on fms_pkg, both channel interfaces,
// fms_decode and fms_serializer.
//
//   Channel   Dir   Handshake       Payload
//   i_evt     in    valid/ready     event_code[3:0], now_ms[31:0]
//   o_res     out   valid/ready     action_code[3:0], new_mode[1:0], calib_ok_flag,
//                                   last_action
//   cfg       in    i_cfg_wr_en     i_cfg_wr_data[31:0] = arm debounce in ms
//
// An accepted event is held in the input register, then it is decoded and its
// one to three actions are loaded into the result register, which hands out one
// transfer per cycle while the result port is ready. The single result port sets
// the pace of events; the input register takes a new event while the previous one
// still plays out. Reset is synchronous and active low; it puts the block in
// calibrate mode with calibration invalid, disarm time zero and a 1000 ms debounce.
// A stalled result port holds the current action and backs up into the input register.
module flight_mode_supervisor_unit #(
    parameter int TIME_WIDTH = fms_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [fms_pkg::DEBOUNCE_W-1:0]    i_cfg_wr_data,
    fms_evt_if.sink                           i_evt,
    fms_res_if.source                         o_res
);

    // Common width used to bring the 32-bit timestamp to TIME_WIDTH bits.
    localparam int CW = (TIME_WIDTH > fms_pkg::NOW_W) ? TIME_WIDTH : fms_pkg::NOW_W;

    // Supervisor state.
    fms_pkg::t_mode                   r_mode;
    logic                             r_cal;
    logic [TIME_WIDTH-1:0]            r_dtime;
    logic [fms_pkg::DEBOUNCE_W-1:0]   r_debounce;

    // Input register.
    logic                             r_in_valid;
    fms_pkg::t_event                  r_event;
    logic [TIME_WIDTH-1:0]            r_now;

    logic [CW-1:0]                    w_now_ext;
    fms_pkg::t_decision               w_dec;
    logic                             w_can_load;
    logic                             w_load;
    logic                             w_in_xfer;

    // The decoded event moves on as soon as the result register is free or is
    // handing out its final action in this cycle.
    assign w_load      = r_in_valid && w_can_load;
    assign i_evt.ready = !r_in_valid || w_load;
    assign w_in_xfer   = i_evt.valid && i_evt.ready;
    assign w_now_ext   = CW'(i_evt.now_ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_event <= i_evt.event_code;
            r_now   <= w_now_ext[TIME_WIDTH-1:0];
        end
    end

    // Write configuration only while idle so it never races a decode; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= fms_pkg::ARM_DEBOUNCE_RST;
        end else if (i_cfg_wr_en) begin
            r_debounce <= i_cfg_wr_data;
        end
    end

    // State advances at the moment an event is committed to the result register,
    // so the next event decodes against up-to-date state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= fms_pkg::MODE_CAL;
            r_cal   <= 1'b0;
            r_dtime <= '0;
        end else if (w_load) begin
            r_mode <= w_dec.mode;
            r_cal  <= w_dec.cal;
            if (w_dec.rec_time) begin
                r_dtime <= r_now;
            end
        end
    end

    fms_decode #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_decode (
        .i_event    (r_event),
        .i_now      (r_now),
        .i_mode     (r_mode),
        .i_cal      (r_cal),
        .i_dtime    (r_dtime),
        .i_debounce (r_debounce),
        .o_dec      (w_dec)
    );

    fms_serializer u_serializer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_dec      (w_dec),
        .o_can_load (w_can_load),
        .o_res      (o_res)
    );

endmodule

FILE: tb/sv/fms_action_checker.sv
`timescale 1ns / 1ps
// Result checker for the flight mode supervisor: watches the event, result and debounce ports,
// predicts every action transfer and compares it with what the block hands out.
// Depends on fms_pkg, fms_evt_if and fms_res_if.
module fms_action_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [fms_pkg::DEBOUNCE_W-1:0] i_cfg_wr_data,
    fms_evt_if                             i_evt,
    fms_res_if                             i_res,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        fms_pkg::t_action act;
        fms_pkg::t_mode   mode;
        logic             cal;
        logic             last;
    } t_action_rec;

    // Supervisor state as this checker sees it.
    fms_pkg::t_mode                 mode_q;
    logic                           cal_q;
    logic [fms_pkg::NOW_W-1:0]      disarm_ms;
    logic [fms_pkg::DEBOUNCE_W-1:0] debounce_ms;
    t_action_rec                    expected_actions[$];

    // Works out the actions of one event and moves the state forward.
    task automatic apply_event(input fms_pkg::t_event ev,
                               input logic [fms_pkg::NOW_W-1:0] now);
        fms_pkg::t_action          acts[$];
        fms_pkg::t_mode            nxt_mode;
        logic                      nxt_cal;
        logic [fms_pkg::NOW_W-1:0] since_disarm;
        t_action_rec               rec;
        nxt_mode     = mode_q;
        nxt_cal      = cal_q;
        since_disarm = now - disarm_ms;
        case (mode_q)
            fms_pkg::MODE_CAL: begin
                if (ev == fms_pkg::EV_CAL_OK) begin
                    nxt_mode = fms_pkg::MODE_DIAG;
                    nxt_cal  = 1'b1;
                    acts.push_back(fms_pkg::ACT_CAL_OK);
                    acts.push_back(fms_pkg::ACT_MODE);
                end else if (ev == fms_pkg::EV_CAL_FAIL || ev == fms_pkg::EV_CAL_TIMEOUT) begin
                    acts.push_back(fms_pkg::ACT_CAL_FAIL);
                end else if (ev == fms_pkg::EV_LOWBATT_CUT) begin
                    nxt_mode = fms_pkg::MODE_DIAG;
                    acts.push_back(fms_pkg::ACT_MOTORS_OFF);
                    acts.push_back(fms_pkg::ACT_LOWBATT);
                end
            end
            fms_pkg::MODE_DIAG: begin
                if (ev == fms_pkg::EV_ARM) begin
                    if (cal_q && since_disarm >= debounce_ms) begin
                        nxt_mode = fms_pkg::MODE_RUN;
                        acts.push_back(fms_pkg::ACT_MODE);
                    end else begin
                        acts.push_back(fms_pkg::ACT_ERROR);
                    end
                end else if (ev == fms_pkg::EV_RECAL) begin
                    nxt_mode = fms_pkg::MODE_CAL;
                    nxt_cal  = 1'b0;
                    acts.push_back(fms_pkg::ACT_MODE);
                end else if (ev == fms_pkg::EV_LOWBATT_CUT) begin
                    acts.push_back(fms_pkg::ACT_MOTORS_OFF);
                    acts.push_back(fms_pkg::ACT_LOWBATT);
                end
            end
            fms_pkg::MODE_RUN: begin
                if (ev == fms_pkg::EV_DISARM || ev == fms_pkg::EV_SWITCH ||
                    ev == fms_pkg::EV_LINK_LOST || ev == fms_pkg::EV_IMU_FAIL) begin
                    acts.push_back(fms_pkg::ACT_RAMP_DOWN);
                    acts.push_back(fms_pkg::ACT_PID_RESET);
                    acts.push_back(fms_pkg::ACT_MODE);
                end else if (ev == fms_pkg::EV_LOWBATT_CRIT) begin
                    acts.push_back(fms_pkg::ACT_RAMP_DOWN);
                    acts.push_back(fms_pkg::ACT_PID_RESET);
                    acts.push_back(fms_pkg::ACT_LOWBATT);
                end else if (ev == fms_pkg::EV_LOWBATT_CUT || ev == fms_pkg::EV_TILT) begin
                    acts.push_back(fms_pkg::ACT_MOTORS_OFF);
                    acts.push_back(fms_pkg::ACT_PID_RESET);
                    acts.push_back(fms_pkg::ACT_MODE);
                end
                if (acts.size() != 0) begin
                    nxt_mode  = fms_pkg::MODE_DIAG;
                    disarm_ms = now;
                end
            end
            default: begin
                nxt_mode = fms_pkg::MODE_DIAG;
                acts.push_back(fms_pkg::ACT_MOTORS_OFF);
                acts.push_back(fms_pkg::ACT_ERROR);
            end
        endcase
        if (acts.size() == 0) begin
            acts.push_back(fms_pkg::ACT_NONE);
        end
        mode_q = nxt_mode;
        cal_q  = nxt_cal;
        foreach (acts[i]) begin
            rec.act  = acts[i];
            rec.mode = nxt_mode;
            rec.cal  = nxt_cal;
            rec.last = (i == acts.size() - 1);
            expected_actions.push_back(rec);
        end
    endtask

    always @(posedge i_clk) begin
        t_action_rec want;
        if (!i_rst_n) begin
            mode_q      = fms_pkg::MODE_CAL;
            cal_q       = 1'b0;
            disarm_ms   = '0;
            debounce_ms = fms_pkg::ARM_DEBOUNCE_RST;
            expected_actions.delete();
        end else begin
            if (i_cfg_wr_en) begin
                debounce_ms = i_cfg_wr_data;
            end
            // Results are retired before the new event is predicted, so a stray
            // result can never match an event taken at the same edge.
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (expected_actions.size() == 0) begin
                    $error("result transfer with no action expected: action_code %0d",
                           i_res.action_code);
                    o_fail_count++;
                end else begin
                    want = expected_actions.pop_front();
                    if (i_res.action_code !== want.act) begin
                        $error("action_code: expected %0d, actual %0d", want.act,
                               i_res.action_code);
                        o_fail_count++;
                    end
                    if (i_res.new_mode !== want.mode) begin
                        $error("new_mode: expected %0d, actual %0d", want.mode,
                               i_res.new_mode);
                        o_fail_count++;
                    end
                    if (i_res.calib_ok_flag !== want.cal) begin
                        $error("calib_ok_flag: expected %0d, actual %0d", want.cal,
                               i_res.calib_ok_flag);
                        o_fail_count++;
                    end
                    if (i_res.last_action !== want.last) begin
                        $error("last_action: expected %0d, actual %0d", want.last,
                               i_res.last_action);
                        o_fail_count++;
                    end
                end
            end
            if (i_evt.valid === 1'b1 && i_evt.ready === 1'b1) begin
                apply_event(i_evt.event_code, i_evt.now_ms);
            end
        end
        o_pending <= expected_actions.size();
    end

endmodule

FILE: tb/sv/tb_flight_mode_supervisor_unit.sv
`timescale 1ns / 1ps
// Testbench top for flight_mode_supervisor_unit: clock, reset, event stimulus, result
// back-pressure and the verdict. Depends on fms_pkg, both channel interfaces and
// fms_action_checker.
module tb_flight_mode_supervisor_unit;

    // Event codes 12 to 15 have no meaning in any mode.
    localparam fms_pkg::t_event EV_SPARE_LO = 4'd12;
    localparam fms_pkg::t_event EV_SPARE_HI = 4'd15;
    localparam int              HOLD_CYCLES = 80;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [fms_pkg::DEBOUNCE_W-1:0] cfg_wr_data;
    int                             fail_count;
    int                             pending;

    // Traffic shaping shared by the sender and the receiver processes.
    logic                  src_steady;
    logic                  sink_steady;
    int                    hold_requests;
    int                    events_sent;

    // What the sender believes about timing, used only to aim arm requests at
    // the debounce boundary. It does not need to be exact.
    logic [fms_pkg::NOW_W-1:0] debounce_ms;
    logic [fms_pkg::NOW_W-1:0] last_exit_ms;

    // Events that end a flight, and events that running mode ignores.
    fms_pkg::t_event exit_codes[7] = '{fms_pkg::EV_LOWBATT_CUT, fms_pkg::EV_DISARM,
                                       fms_pkg::EV_SWITCH, fms_pkg::EV_LINK_LOST,
                                       fms_pkg::EV_IMU_FAIL, fms_pkg::EV_LOWBATT_CRIT,
                                       fms_pkg::EV_TILT};
    fms_pkg::t_event run_ignored[6] = '{fms_pkg::EV_CAL_OK, fms_pkg::EV_CAL_FAIL,
                                        fms_pkg::EV_ARM, fms_pkg::EV_RECAL,
                                        EV_SPARE_LO, EV_SPARE_HI};

    fms_evt_if evt_ch();
    fms_res_if res_ch();

    flight_mode_supervisor_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_evt         (evt_ch),
        .o_res         (res_ch)
    );

    fms_action_checker action_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_evt         (evt_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    // Offers one event and returns at the edge where its transfer happens. Random idle
    // cycles go in front of it unless the sender is in a steady stretch. Every path
    // makes at most one assignment to valid between clock edges, so a valid that stays high
    // from one event to the next is never dropped and raised in the same step.
    task automatic send_event(input fms_pkg::t_event code,
                              input logic [fms_pkg::NOW_W-1:0] now);
        while (!src_steady && $urandom_range(99) < 28) begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.event_code <= code;
        evt_ch.now_ms     <= now;
        do @(posedge clk); while (evt_ch.ready !== 1'b1);
        events_sent++;
    endtask

    // Stops offering events and waits until the checker has seen every expected result.
    // Every event yields at least one result, so the block is idle once this returns.
    task automatic wait_for_results();
        evt_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // The debounce register is only written while the block is idle.
    task automatic set_debounce(input logic [fms_pkg::DEBOUNCE_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        debounce_ms = value;
    endtask

    // One complete flight: recalibrate, possibly fail calibration first, calibrate, possibly
    // cut for low battery, arm close to the debounce boundary or at a random time, up to
    // two events that running mode ignores, and one of the events that take the block back to diagnostic mode.
    task automatic fly_once();
        logic [fms_pkg::NOW_W-1:0] arm_at;
        logic [fms_pkg::NOW_W-1:0] exit_at;
        int                        pick;
        send_event(fms_pkg::EV_RECAL, $urandom());
        if ($urandom_range(2) == 0) begin
            send_event($urandom_range(1) ? fms_pkg::EV_CAL_FAIL : fms_pkg::EV_CAL_TIMEOUT,
                       $urandom());
        end
        send_event(fms_pkg::EV_CAL_OK, $urandom());
        if ($urandom_range(3) == 0) begin
            send_event(fms_pkg::EV_LOWBATT_CUT, $urandom());
        end
        pick = $urandom_range(3);
        case (pick)
            0: arm_at = last_exit_ms + debounce_ms - 1;
            1: arm_at = last_exit_ms + debounce_ms;
            2: arm_at = last_exit_ms + debounce_ms + $urandom_range(1, 100);
            default: arm_at = $urandom();
        endcase
        send_event(fms_pkg::EV_ARM, arm_at);
        // An arm one millisecond short is refused unless the debounce is zero; try again right on the boundary.
        if (pick == 0) begin
            send_event(fms_pkg::EV_ARM, last_exit_ms + debounce_ms);
        end
        repeat ($urandom_range(2)) begin
            send_event(run_ignored[$urandom_range(5)], $urandom());
        end
        exit_at = $urandom();
        send_event(exit_codes[$urandom_range(6)], exit_at);
        last_exit_ms = exit_at;
    endtask

    // Mostly well-formed flights; the rest are single events of any code at any time.
    task automatic run_random(input int count);
        int target;
        target = events_sent + count;
        while (events_sent < target) begin
            if ($urandom_range(99) < 15) begin
                send_event(fms_pkg::t_event'($urandom_range(15)), $urandom());
            end else begin
                fly_once();
            end
        end
    endtask

    // Result receiver. It stalls at random, takes everything during a steady stretch,
    // and on request holds ready low for a counted stretch of cycles.
    initial begin : result_sink
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (sink_steady) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= 28);
            end
        end
    end

    initial begin : stimulus
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        evt_ch.valid      <= 1'b0;
        evt_ch.event_code <= fms_pkg::EV_CAL_OK;
        evt_ch.now_ms     <= '0;
        src_steady    = 1'b0;
        sink_steady   = 1'b0;
        hold_requests = 0;
        events_sent   = 0;
        debounce_ms   = fms_pkg::ARM_DEBOUNCE_RST;
        last_exit_ms  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from calibrate mode with the reset debounce of 1000 ms.
        // Unused codes and the time extremes first: no effect, a single none action.
        send_event(EV_SPARE_LO, 32'h0000_0000);
        send_event(EV_SPARE_HI, 32'hFFFF_FFFF);
        send_event(fms_pkg::EV_CAL_FAIL, 32'd5);
        send_event(fms_pkg::EV_CAL_TIMEOUT, 32'd6);
        // Low battery straight out of calibrate leaves calibration invalid, so the
        // arm request that follows is refused.
        send_event(fms_pkg::EV_LOWBATT_CUT, 32'd7);
        send_event(fms_pkg::EV_ARM, 32'd8);
        send_event(fms_pkg::EV_RECAL, 32'd9);
        send_event(fms_pkg::EV_CAL_OK, 32'd10);
        send_event(fms_pkg::EV_LOWBATT_CUT, 32'd11);
        send_event(fms_pkg::EV_TILT, 32'd12);
        // The disarm time is still zero: 999 ms is one short, 1000 ms is enough.
        send_event(fms_pkg::EV_ARM, 32'd999);
        send_event(fms_pkg::EV_ARM, 32'd1000);
        send_event(fms_pkg::EV_CAL_OK, 32'd1001);
        // A disarm just before the time counter wraps, then arm requests after the
        // wrap that are one short of and exactly at the debounce.
        send_event(fms_pkg::EV_SWITCH, 32'hFFFF_FF00);
        send_event(fms_pkg::EV_ARM, 32'h0000_02E7);
        send_event(fms_pkg::EV_ARM, 32'h0000_02E8);
        // Every remaining way out of running mode.
        send_event(fms_pkg::EV_LOWBATT_CRIT, 32'd5000);
        send_event(fms_pkg::EV_ARM, 32'd6000);
        send_event(fms_pkg::EV_TILT, 32'd7000);
        send_event(fms_pkg::EV_ARM, 32'd8000);
        send_event(fms_pkg::EV_LOWBATT_CUT, 32'd9000);
        send_event(fms_pkg::EV_ARM, 32'd10000);
        send_event(fms_pkg::EV_DISARM, 32'd11000);
        send_event(fms_pkg::EV_ARM, 32'd12000);
        send_event(fms_pkg::EV_LINK_LOST, 32'd13000);
        send_event(fms_pkg::EV_ARM, 32'd14000);
        send_event(fms_pkg::EV_IMU_FAIL, 32'd15000);
        last_exit_ms = 32'd15000;

        // No debounce at all: every arm with a valid calibration is taken.
        set_debounce('0);
        run_random(50);

        // Largest debounce: only an elapsed time of all ones passes. The receiver
        // holds off for a while here and the sender keeps pushing, so the block
        // fills up and stalls its event input.
        set_debounce('1);
        hold_requests++;
        src_steady = 1'b1;
        run_random(20);
        src_steady = 1'b0;
        run_random(30);

        // Random debounce, with a stretch where neither side idles.
        set_debounce($urandom());
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        run_random(35);
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        run_random(15);

        // A realistic debounce in the low seconds.
        set_debounce($urandom_range(1, 5000));
        run_random(60);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("flight_mode_supervisor_unit regression: pass");
        end else begin
            $display("flight_mode_supervisor_unit regression: fail");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("flight_mode_supervisor_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fms_pkg.sv
rtl/core/fms_evt_if.sv
rtl/core/fms_res_if.sv
rtl/core/fms_decode.sv
rtl/core/fms_serializer.sv
rtl/core/flight_mode_supervisor_unit.sv
tb/sv/fms_action_checker.sv
tb/sv/tb_flight_mode_supervisor_unit.sv
